// ===== hdl/bbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bollinger band tracker package
// Shared constants, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bbt_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  localparam int PRICE_W    = 24;
  localparam int LEN_REG_W  = 7;
  localparam int MULT_W     = 12;
  localparam int MULT_FRAC  = 8;
  localparam int BAND_W     = 28;
  localparam int LEN_RESET  = 20;
  localparam int MULT_RESET = 512;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_BAND_MULTIPLIER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACCUM,
    ST_PROD,
    ST_DIV_INIT,
    ST_DIV,
    ST_ROOT,
    ST_SCALE,
    ST_BAND,
    ST_ZERO
  } bbt_state_t;

  typedef struct packed {
    logic start;
    logic update;
    logic accum;
    logic prod_step;
    logic div_init;
    logic div_step;
    logic root_step;
    logic scale;
    logic load_band;
    logic load_zero;
  } bbt_cmd_t;

  typedef struct packed {
    logic window_full;
    logic out_free;
  } bbt_status_t;

endpackage

// ===== hdl/bbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bollinger band tracker controller
// Sequences the window update, the multiply, the divisions, the square root
// and the band output for one price at a time.
// ----------------------------------------------------------------------------
module bbt_ctrl #(
  parameter int LEN_STEPS  = 7,
  parameter int DIV_STEPS  = 30,
  parameter int ROOT_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                price_valid,
  output logic                price_stall,
  input  bbt_pkg::bbt_status_t status,
  output bbt_pkg::bbt_cmd_t    cmd
);

  localparam int MAX_A     = (DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS;
  localparam int MAX_STEPS = (MAX_A > LEN_STEPS) ? MAX_A : LEN_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  bbt_pkg::bbt_state_t state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbt_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    price_stall = 1'b1;
    case (state)
      bbt_pkg::ST_IDLE: begin
        price_stall = 1'b0;
        if (price_valid) begin
          cmd.start  = 1'b1;
          state_next = bbt_pkg::ST_UPDATE;
        end
      end
      bbt_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = bbt_pkg::ST_ACCUM;
      end
      bbt_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
        cnt_next  = '0;
        if (status.window_full) begin
          state_next = bbt_pkg::ST_PROD;
        end else begin
          state_next = bbt_pkg::ST_ZERO;
        end
      end
      bbt_pkg::ST_PROD: begin
        cmd.prod_step = 1'b1;
        if (cnt == CNT_W'(LEN_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = bbt_pkg::ST_DIV_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bbt_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = bbt_pkg::ST_DIV;
      end
      bbt_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = bbt_pkg::ST_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bbt_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = bbt_pkg::ST_SCALE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bbt_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = bbt_pkg::ST_BAND;
      end
      bbt_pkg::ST_BAND: begin
        if (status.out_free) begin
          cmd.load_band = 1'b1;
          state_next    = bbt_pkg::ST_IDLE;
        end
      end
      bbt_pkg::ST_ZERO: begin
        if (status.out_free) begin
          cmd.load_zero = 1'b1;
          state_next    = bbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bbt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bbt_datapath.sv =====
// ----------------------------------------------------------------------------
// Bollinger band tracker datapath
// Window store, running sums, shift-add multiply, radix-4 variance divider,
// bit-serial mean divider, digit-by-digit square root and output register.
// ----------------------------------------------------------------------------
module bbt_datapath #(
  parameter int MAX_WINDOW = bbt_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = bbt_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bbt_pkg::bbt_cmd_t                   cmd,
  output bbt_pkg::bbt_status_t                status,
  input  logic                                restart,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     len,
  input  logic [bbt_pkg::MULT_W-1:0]          mult,
  input  logic [PRICE_BITS-1:0]               price_in,
  output logic                                band_valid,
  input  logic                                band_stall,
  output logic                                bands_ready,
  output logic [bbt_pkg::BAND_W-1:0]          high_band,
  output logic signed [bbt_pkg::BAND_W-1:0]   low_band
);

  localparam int LOG_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = LOG_W;
  localparam int SUM_W  = PRICE_BITS + LOG_W;
  localparam int SQ_W   = 2 * PRICE_BITS + LOG_W;
  localparam int NUM_W  = 2 * SUM_W;
  localparam int D2_W   = 2 * LEN_W;
  localparam int VAR_W  = 2 * PRICE_BITS;
  localparam int PROD_W = bbt_pkg::MULT_W + PRICE_BITS;
  localparam int BW     = bbt_pkg::BAND_W;

  logic [PRICE_BITS-1:0]   price_q;
  logic [PRICE_BITS-1:0]   ram_rd;
  logic [SLOT_W-1:0]       write_slot;
  logic [LEN_W-1:0]        seen_count;
  logic [SUM_W-1:0]        total;
  logic [SQ_W-1:0]         sq_total;
  logic [VAR_W-1:0]        old_sq;
  logic [VAR_W-1:0]        new_sq;
  logic [NUM_W-1:0]        acc;
  logic [NUM_W-1:0]        ss;
  logic [LEN_W-1:0]        nsh;
  logic [D2_W-1:0]         d2;
  logic [D2_W-1:0]         drem;
  logic [NUM_W-1:0]        dq;
  logic [LEN_W-1:0]        mrem;
  logic [SUM_W-1:0]        mq;
  logic [PRICE_BITS+1:0]   rrem;
  logic [PRICE_BITS-1:0]   root;
  logic [PROD_W-1:0]       scaled_prod;

  logic                    window_full;
  logic [PRICE_BITS-1:0]   old_eff;
  logic [SLOT_W:0]         slot_inc;
  logic [NUM_W-1:0]        ss_prod;
  logic [D2_W:0]           t1, t2, r1, r2;
  logic                    ge1, ge2;
  logic [LEN_W:0]          mt, mr;
  logic                    mge;
  logic [PRICE_BITS+3:0]   rt, trial, rr;
  logic                    rge;
  logic [BW-1:0]           mean_b, scaled_b;

  assign window_full        = (seen_count >= len);
  assign status.window_full = window_full;
  assign status.out_free    = !band_valid || !band_stall;

  bbt_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (write_slot),
    .wdata (price_q),
    .re    (cmd.start),
    .raddr (write_slot),
    .rdata (ram_rd)
  );

  // The oldest price only leaves the sums once the window is full.
  assign old_eff  = window_full ? ram_rd : '0;
  assign slot_inc = {1'b0, write_slot} + 1'b1;
  assign ss_prod  = total * total;

  // Variance divider: two restoring steps per cycle.
  assign t1  = {drem, dq[NUM_W-1]};
  assign ge1 = (t1 >= {1'b0, d2});
  assign r1  = ge1 ? (t1 - {1'b0, d2}) : t1;
  assign t2  = {r1[D2_W-1:0], dq[NUM_W-2]};
  assign ge2 = (t2 >= {1'b0, d2});
  assign r2  = ge2 ? (t2 - {1'b0, d2}) : t2;

  // Mean divider: one restoring step per cycle.
  assign mt  = {mrem, mq[SUM_W-1]};
  assign mge = (mt >= {1'b0, len});
  assign mr  = mge ? (mt - {1'b0, len}) : mt;

  // Square root: one result bit per cycle from the next pair of variance bits.
  assign rt    = {rrem, dq[VAR_W-1 -: 2]};
  assign trial = (PRICE_BITS + 4)'({root, 2'b01});
  assign rge   = (rt >= trial);
  assign rr    = rge ? (rt - trial) : rt;

  assign mean_b   = BW'(mq);
  assign scaled_b = BW'(scaled_prod >> bbt_pkg::MULT_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      seen_count <= '0;
      total      <= '0;
      sq_total   <= '0;
    end else if (restart) begin
      write_slot <= '0;
      seen_count <= '0;
      total      <= '0;
      sq_total   <= '0;
    end else begin
      if (cmd.update) begin
        total <= total - SUM_W'(old_eff) + SUM_W'(price_q);
        if (slot_inc >= (SLOT_W + 1)'(len)) begin
          write_slot <= '0;
        end else begin
          write_slot <= slot_inc[SLOT_W-1:0];
        end
        if (!window_full) begin
          seen_count <= seen_count + 1'b1;
        end
      end
      if (cmd.accum) begin
        sq_total <= sq_total - SQ_W'(old_sq) + SQ_W'(new_sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      price_q <= price_in;
    end
    if (cmd.update) begin
      old_sq <= old_eff * old_eff;
      new_sq <= price_q * price_q;
    end
    if (cmd.accum) begin
      acc <= '0;
      nsh <= len;
      ss  <= ss_prod;
    end
    if (cmd.prod_step) begin
      acc <= {acc[NUM_W-2:0], 1'b0} + (nsh[LEN_W-1] ? NUM_W'(sq_total) : '0);
      nsh <= {nsh[LEN_W-2:0], 1'b0};
    end
    if (cmd.div_init) begin
      dq   <= acc - ss;
      drem <= '0;
      d2   <= D2_W'(len) * D2_W'(len);
      mq   <= total;
      mrem <= '0;
      rrem <= '0;
      root <= '0;
    end
    if (cmd.div_step) begin
      dq   <= {dq[NUM_W-3:0], ge1, ge2};
      drem <= r2[D2_W-1:0];
      mq   <= {mq[SUM_W-2:0], mge};
      mrem <= mr[LEN_W-1:0];
    end
    if (cmd.root_step) begin
      dq   <= {dq[NUM_W-3:0], 2'b00};
      rrem <= rr[PRICE_BITS+1:0];
      root <= {root[PRICE_BITS-2:0], rge};
    end
    if (cmd.scale) begin
      scaled_prod <= mult * root;
    end
    if (cmd.load_band) begin
      bands_ready <= 1'b1;
      high_band   <= mean_b + scaled_b;
      low_band    <= signed'(mean_b - scaled_b);
    end else if (cmd.load_zero) begin
      bands_ready <= 1'b0;
      high_band   <= '0;
      low_band    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_valid <= 1'b0;
    end else if (cmd.load_band || cmd.load_zero) begin
      band_valid <= 1'b1;
    end else if (!band_stall) begin
      band_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/bollinger_band_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Bollinger band tracker core: a price taken on a full window goes through the
// window update, multiply, divisions and square root (the last two the longest)
// before its result; while filling, a zero-band result follows the update. No
// new price is taken until the result is loaded. Synchronous reset clears the
// window and restores length 20 and multiplier 2.0.
// ----------------------------------------------------------------------------
module bollinger_band_tracker_core #(
  parameter int MAX_WINDOW = bbt_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = bbt_pkg::PRICE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bbt_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [bbt_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [bbt_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  price_valid,
  output logic                                  price_stall,
  input  logic [bbt_pkg::PRICE_W-1:0]           price,
  output logic                                  band_valid,
  input  logic                                  band_stall,
  output logic                                  bands_ready,
  output logic [bbt_pkg::BAND_W-1:0]            high_band,
  output logic signed [bbt_pkg::BAND_W-1:0]     low_band
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);

  logic [bbt_pkg::LEN_REG_W-1:0] window_length;
  logic [bbt_pkg::MULT_W-1:0]    band_multiplier;
  logic                          cfg_write;
  logic                          restart;
  logic [LEN_W-1:0]              len_eff;
  bbt_pkg::bbt_cmd_t             cmd;
  bbt_pkg::bbt_status_t          status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign restart   = cfg_write && (paddr[2] == bbt_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= bbt_pkg::LEN_REG_W'(bbt_pkg::LEN_RESET);
      band_multiplier <= bbt_pkg::MULT_W'(bbt_pkg::MULT_RESET);
    end else if (cfg_write) begin
      case (paddr[2])
        bbt_pkg::REG_WINDOW_LENGTH: begin
          window_length <= pwdata[bbt_pkg::LEN_REG_W-1:0];
        end
        bbt_pkg::REG_BAND_MULTIPLIER: begin
          band_multiplier <= pwdata[bbt_pkg::MULT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bbt_pkg::REG_WINDOW_LENGTH:   prdata = bbt_pkg::APB_DATA_W'(window_length);
      bbt_pkg::REG_BAND_MULTIPLIER: prdata = bbt_pkg::APB_DATA_W'(band_multiplier);
      default:                      prdata = '0;
    endcase
  end

  // A zero length behaves as one; anything beyond the store is clamped to it.
  always_comb begin
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_length > bbt_pkg::LEN_REG_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(window_length);
    end
  end

  bbt_ctrl #(
    .LEN_STEPS  (LEN_W),
    .DIV_STEPS  (SUM_W),
    .ROOT_STEPS (PRICE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .price_valid (price_valid),
    .price_stall (price_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bbt_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .restart     (restart),
    .len         (len_eff),
    .mult        (band_multiplier),
    .price_in    (price[PRICE_BITS-1:0]),
    .band_valid  (band_valid),
    .band_stall  (band_stall),
    .bands_ready (bands_ready),
    .high_band   (high_band),
    .low_band    (low_band)
  );

`ifndef SYNTHESIS
  // Only one price is in flight: the transaction just taken blocks the next.
  assert property (@(posedge clk) disable iff (rst)
    (price_valid && !price_stall) |=> price_stall)
    else $error("price taken while previous one still in progress");

  // A result appears only when the controller commands a load.
  assert property (@(posedge clk) disable iff (rst)
    $rose(band_valid) |-> $past(cmd.load_band || cmd.load_zero))
    else $error("band result appeared without a load command");

  // Results given before the window is full carry zero bands.
  assert property (@(posedge clk) disable iff (rst)
    (band_valid && !bands_ready) |-> (high_band == '0 && low_band == '0))
    else $error("non-zero bands on a not-ready result");
`endif

endmodule

// ===== tb/bollinger_band_tracker_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bollinger band tracker core testbench
// Drives prices through the valid/stall input channel with random gaps, and
// programs the window length and band multiplier through the APB port between
// phases, reading each register back. A scoreboard keeps its own copy of the
// price window, sums and registers, predicts the bands of every accepted
// price and checks each band transaction in order. The output side stalls at
// random.
// ----------------------------------------------------------------------------
module bollinger_band_tracker_core_tb;
  import bbt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [MULT_W-1:0]  MULT_MAX  = {MULT_W{1'b1}};

  typedef struct packed {
    logic              ready;
    logic [BAND_W-1:0] upper;
    logic [BAND_W-1:0] lower;
  } band_result_t;

  typedef enum int {PRICES_ANY, PRICES_NEAR, PRICES_EXTREME, PRICES_FLAT} price_mix_t;

  class band_scoreboard;
    logic [LEN_REG_W-1:0] length_reg;
    logic [MULT_W-1:0]    multiplier;
    logic [PRICE_W-1:0]   window [MAX_WINDOW_DEF];
    int unsigned          slot;
    int unsigned          seen;
    longint unsigned      total;
    longint unsigned      square_total;
    band_result_t         expected_bands [$];
    int                   failures;

    function new();
      length_reg = LEN_REG_W'(LEN_RESET);
      multiplier = MULT_W'(MULT_RESET);
      failures   = 0;
      restart();
    endfunction

    function void restart();
      slot         = 0;
      seen         = 0;
      total        = 0;
      square_total = 0;
    endfunction

    // A window length write always starts a fresh window; the multiplier
    // only changes the scaling of later prices.
    function void write_reg(logic index, logic [APB_DATA_W-1:0] value);
      if (index == REG_WINDOW_LENGTH) begin
        length_reg = value[LEN_REG_W-1:0];
        restart();
      end else begin
        multiplier = value[MULT_W-1:0];
      end
    endfunction

    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return int'(length_reg);
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    function int pending();
      return expected_bands.size();
    endfunction

    function void note_price(logic [PRICE_W-1:0] value);
      longint unsigned n;
      longint unsigned pv;
      longint unsigned old;
      longint unsigned mean;
      longint unsigned spread;
      longint unsigned scaled;
      longint unsigned high_sum;
      longint          low_sum;
      band_result_t    r;
      n  = 64'(span());
      pv = 64'(value);
      if (seen >= n) begin
        old          = 64'(window[slot]);
        total        = total - old;
        square_total = square_total - old * old;
      end
      window[slot] = value;
      total        = total + pv;
      square_total = square_total + pv * pv;
      slot         = (slot + 1 >= n) ? 0 : slot + 1;
      if (seen < n) seen++;
      r = '0;
      if (seen >= n) begin
        mean     = total / n;
        spread   = (n * square_total - total * total) / (n * n);
        scaled   = (64'(multiplier) * int_root(spread)) >> MULT_FRAC;
        high_sum = mean + scaled;
        low_sum  = $signed(mean) - $signed(scaled);
        r.ready  = 1'b1;
        r.upper  = high_sum[BAND_W-1:0];
        r.lower  = low_sum[BAND_W-1:0];
      end
      expected_bands = {expected_bands, r};
    endfunction

    function void check_bands(logic ready, logic [BAND_W-1:0] upper,
                              logic [BAND_W-1:0] lower);
      band_result_t e;
      if (expected_bands.size() == 0) begin
        $error("band transaction with no price outstanding: ready %0d upper %h lower %h",
               ready, upper, lower);
        failures++;
        return;
      end
      e = expected_bands.pop_front();
      if (ready !== e.ready) begin
        $error("bands_ready: expected %0d, got %0d", e.ready, ready);
        failures++;
      end
      if (upper !== e.upper) begin
        $error("high_band: expected %0d, got %0d", e.upper, upper);
        failures++;
      end
      if (lower !== e.lower) begin
        $error("low_band: expected %0d, got %0d", $signed(e.lower), $signed(lower));
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  price_valid = 1'b0;
  logic                  price_stall;
  logic [PRICE_W-1:0]    price = '0;
  logic                  band_valid;
  logic                  band_stall = 1'b0;
  logic                  bands_ready;
  logic [BAND_W-1:0]     high_band;
  logic signed [BAND_W-1:0] low_band;

  band_scoreboard bands;
  bit             steady_flow = 1'b0;
  int             sent_count  = 0;
  int             cycle_count = 0;

  bollinger_band_tracker_core uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bollinger_band_tracker_core regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all in steady phases.
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(90, 20);
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price(price_mix_t mix,
                                                    logic [PRICE_W-1:0] anchor);
    logic [PRICE_W-1:0] offset;
    offset = PRICE_W'($urandom_range(8191));
    case (mix)
      PRICES_NEAR:    return anchor + offset - PRICE_W'(4096);
      PRICES_EXTREME: return ($urandom_range(1) == 1) ? PRICE_MAX : '0;
      PRICES_FLAT:    return ($urandom_range(7) == 0) ? PRICE_W'($urandom) : anchor;
      default:        return PRICE_W'($urandom);
    endcase
  endfunction

  // One APB transfer, after which the bus is left idle.
  task automatic apb_access(input logic write_en, input logic index,
                            input logic [APB_DATA_W-1:0] value,
                            output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= APB_ADDR_W'(index) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic index, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    logic [APB_DATA_W-1:0] mask;
    apb_access(1'b0, index, '0, data);
    mask = (index == REG_WINDOW_LENGTH) ? APB_DATA_W'({LEN_REG_W{1'b1}})
                                        : APB_DATA_W'({MULT_W{1'b1}});
    if ((data & mask) !== (value & mask)) begin
      $error("%s readback: expected %0d, got %0d",
             (index == REG_WINDOW_LENGTH) ? "window_length" : "band_multiplier",
             value & mask, data & mask);
      bands.failures++;
    end
  endtask

  task automatic set_register(input logic index, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    apb_access(1'b1, index, value, data);
    bands.write_reg(index, value);
    check_register(index, value);
  endtask

  task automatic send_price(input logic [PRICE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      price_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    price_valid <= 1'b1;
    price       <= value;
    do @(posedge clk); while (price_stall);
    bands.note_price(value);
    sent_count++;
  endtask

  // Stops the price stream and waits for every outstanding band transaction.
  task automatic settle();
    price_valid <= 1'b0;
    while (bands.pending() != 0) @(posedge clk);
  endtask

  initial begin : band_sink
    int hold;
    int free;
    hold = 0;
    free = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (band_valid && !band_stall) begin
        bands.check_bands(bands_ready, high_band, low_band);
      end
      if (hold > 0) begin
        hold--;
        band_stall <= 1'b1;
      end else begin
        band_stall <= 1'b0;
        if (free > 0) begin
          free--;
        end else begin
          hold = pick_gap();
          free = $urandom_range(6);
        end
      end
    end
  end

  initial begin : stimulus
    int                    roll;
    int                    count;
    int                    cut;
    int                    goal;
    logic [APB_DATA_W-1:0] len_value;
    logic [APB_DATA_W-1:0] mult_value;
    logic [PRICE_W-1:0]    anchor;
    price_mix_t            mix;
    bands = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, and a few prices that cannot fill the reset window.
    check_register(REG_WINDOW_LENGTH, APB_DATA_W'(LEN_RESET));
    check_register(REG_BAND_MULTIPLIER, APB_DATA_W'(MULT_RESET));
    send_price(PRICE_W'(24'h001000));
    send_price(PRICE_MAX);
    send_price('0);
    settle();

    // Widest spread with the largest multiplier drives the lower band negative.
    set_register(REG_WINDOW_LENGTH, 4);
    set_register(REG_BAND_MULTIPLIER, APB_DATA_W'(MULT_MAX));
    send_price('0);
    send_price(PRICE_MAX);
    send_price('0);
    send_price(PRICE_MAX);
    send_price(PRICE_MAX);
    settle();

    // A zero multiplier keeps the window; the bands collapse onto the mean.
    set_register(REG_BAND_MULTIPLIER, 0);
    send_price(PRICE_MAX);
    send_price('0);
    settle();

    // Length zero behaves as a window of one.
    set_register(REG_WINDOW_LENGTH, 0);
    set_register(REG_BAND_MULTIPLIER, APB_DATA_W'(MULT_RESET));
    send_price(PRICE_W'(24'h123456));
    send_price(PRICE_MAX);
    send_price('0);
    settle();

    // A flat window has no deviation.
    set_register(REG_WINDOW_LENGTH, 2);
    send_price(PRICE_W'(24'h000800));
    send_price(PRICE_W'(24'h000800));
    send_price(PRICE_W'(24'h000800));
    settle();

    // Every register bit set: the length saturates at the largest window.
    set_register(REG_WINDOW_LENGTH, '1);
    set_register(REG_BAND_MULTIPLIER, '1);

    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      roll = $urandom_range(99);
      if (roll < 35) len_value = $urandom_range(4, 1);
      else if (roll < 65) len_value = $urandom_range(16, 5);
      else if (roll < 85) len_value = $urandom_range(40, 17);
      else begin
        case ($urandom_range(4))
          0:       len_value = MAX_WINDOW_DEF;
          1:       len_value = 0;
          2:       len_value = $urandom_range(127, MAX_WINDOW_DEF + 1);
          3:       len_value = LEN_RESET;
          default: len_value = MAX_WINDOW_DEF - 1;
        endcase
      end
      if ($urandom_range(3) == 0) len_value = len_value | ($urandom << LEN_REG_W);
      case ($urandom_range(5))
        0:       mult_value = 0;
        1:       mult_value = APB_DATA_W'(MULT_MAX);
        2:       mult_value = APB_DATA_W'(MULT_RESET);
        default: mult_value = $urandom_range(MULT_MAX);
      endcase
      set_register(REG_WINDOW_LENGTH, len_value);
      set_register(REG_BAND_MULTIPLIER, mult_value);

      mix         = price_mix_t'($urandom_range(3));
      anchor      = PRICE_W'($urandom);
      steady_flow = ($urandom_range(3) == 0);
      count       = int'(bands.span()) + $urandom_range(40, 4);
      cut         = ($urandom_range(3) == 0) ? $urandom_range(count - 1, 1) : -1;
      for (int i = 0; i < count; i++) begin
        // A multiplier change part way through keeps the window contents.
        if (i == cut) begin
          settle();
          set_register(REG_BAND_MULTIPLIER, $urandom_range(MULT_MAX));
        end
        send_price(pick_price(mix, anchor));
      end
      settle();
    end

    steady_flow = 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bands.failures == 0 && bands.pending() == 0) begin
      $display("bollinger_band_tracker_core regression: pass");
    end else begin
      $display("bollinger_band_tracker_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bbt_pkg.sv
hdl/bbt_ram.sv
hdl/bbt_ctrl.sv
hdl/bbt_datapath.sv
hdl/bollinger_band_tracker_core.sv
tb/bollinger_band_tracker_core_tb.sv
